@@ hdl/url_enc_pkg.sv @@
// Package for the URL percent encoder: the transfer record passed from the
// classifier to the serializer and the byte classification helpers.
// Depends on nothing.
package url_enc_pkg;

	// Printable range that may pass through unchanged.
	localparam logic [7:0] SAFE_LOW  = 8'd33;
	localparam logic [7:0] SAFE_HIGH = 8'd122;
	localparam logic [7:0] PCT_CHAR  = 8'h25;

	// Classified byte, ready for serialization.
	typedef struct packed {
		logic       escape;
		logic [7:0] raw_byte;
		logic [7:0] hi_digit;
		logic [7:0] lo_digit;
		logic       text_end;
	} enc_item_t;

	// Output slot within one escaped run.
	typedef enum logic [2:0] {
		PH_PCT = 3'b001,
		PH_HI  = 3'b010,
		PH_LO  = 3'b100
	} enc_phase_t;

	// Decide whether a byte must become a percent triplet.
	function automatic logic needs_escape(input logic [7:0] b);
		logic esc;
		esc = 1'b0;
		if (b < SAFE_LOW || b > SAFE_HIGH) begin
			esc = 1'b1;
		end else begin
			// " < > % \ ^ [ ] ` + $ , @ : ; / ! # ? = &
			case (b) inside
				8'h22, 8'h3C, 8'h3E, 8'h25, 8'h5C, 8'h5E, 8'h5B, 8'h5D,
				8'h60, 8'h2B, 8'h24, 8'h2C, 8'h40, 8'h3A, 8'h3B, 8'h2F,
				8'h21, 8'h23, 8'h3F, 8'h3D, 8'h26: esc = 1'b1;
				default: esc = 1'b0;
			endcase
		end
		return esc;
	endfunction

	// Map a nibble to its upper-case hex character.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'h0, n};
		end else begin
			c = 8'h37 + {4'h0, n};
		end
		return c;
	endfunction

endpackage

@@ hdl/url_enc_classify.sv @@
// Classifier for the URL percent encoder: flags bytes that need escaping
// and forms their hex digits. Depends on url_enc_pkg.
module url_enc_classify (
	input  logic                  [7:0] byte_in,
	input  logic                        end_in,
	output url_enc_pkg::enc_item_t      item
);

	// Build the record for the held byte.
	always_comb begin
		item.escape   = url_enc_pkg::needs_escape(byte_in);
		item.raw_byte = byte_in;
		item.hi_digit = url_enc_pkg::hex_char(byte_in[7:4]);
		item.lo_digit = url_enc_pkg::hex_char(byte_in[3:0]);
		item.text_end = end_in;
	end

endmodule

@@ hdl/url_enc_serializer.sv @@
// Serializer for the URL percent encoder: steps through the one or three
// output bytes of a classified item into the output register.
// Depends on url_enc_pkg.
module url_enc_serializer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  url_enc_pkg::enc_item_t     item,
	output logic                       item_done,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                 [7:0] out_byte,
	output logic                       run_last,
	output logic                       end_of_text
);

	url_enc_pkg::enc_phase_t phase_q;
	logic                    load;
	logic                    is_last;
	logic              [7:0] sel_byte;
	logic                    out_valid_q;
	logic              [7:0] out_byte_q;
	logic                    run_last_q;
	logic                    end_of_text_q;

	// Output register is free when empty or being drained this cycle.
	assign load = !out_valid_q || out_ready;

	// Pick the byte for the current slot.
	always_comb begin
		sel_byte = item.raw_byte;
		is_last  = 1'b1;
		if (item.escape) begin
			unique case (phase_q)
				url_enc_pkg::PH_PCT: begin
					sel_byte = url_enc_pkg::PCT_CHAR;
					is_last  = 1'b0;
				end
				url_enc_pkg::PH_HI: begin
					sel_byte = item.hi_digit;
					is_last  = 1'b0;
				end
				url_enc_pkg::PH_LO: begin
					sel_byte = item.lo_digit;
					is_last  = 1'b1;
				end
				default: begin
					sel_byte = item.raw_byte;
					is_last  = 1'b1;
				end
			endcase
		end
	end

	assign item_done = item_valid && load && is_last;

	// Advance the slot counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= url_enc_pkg::PH_PCT;
		end else if (item_valid && load) begin
			unique case (phase_q)
				url_enc_pkg::PH_PCT: phase_q <= is_last ? url_enc_pkg::PH_PCT
				                                        : url_enc_pkg::PH_HI;
				url_enc_pkg::PH_HI:  phase_q <= url_enc_pkg::PH_LO;
				url_enc_pkg::PH_LO:  phase_q <= url_enc_pkg::PH_PCT;
				default:             phase_q <= url_enc_pkg::PH_PCT;
			endcase
		end
	end

	// Hold or refill the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= item_valid;
		end
	end

	// Load the output payload.
	always_ff @(posedge clk) begin
		if (load && item_valid) begin
			out_byte_q    <= sel_byte;
			run_last_q    <= is_last;
			end_of_text_q <= is_last && item.text_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign end_of_text = end_of_text_q;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("slot counter lost one-hot code");

	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != url_enc_pkg::PH_PCT |-> item_valid && item.escape)
		else $error("mid-run slot without an escaped item");

	a_eot_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !end_of_text)
		else $error("end of text raised before the end of a run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("escaped run broken after a transfer");

endmodule

@@ hdl/url_percent_encoder.sv @@
// URL percent encoder.
// Input channel (in_valid/in_ready) carries one text byte, text_byte, and
// text_end, which marks the last byte of the text. Output channel
// (out_valid/out_ready) carries out_byte with run_last on the final byte of
// each input and end_of_text on the final byte of the last input.
// A byte in 33..122 that is not a reserved character passes through as one
// transfer; any other byte becomes '%' and two upper-case hex digits.
// Each input byte passes through the input register, then the output
// register, before it can transfer; a stalled receiver holds it in the
// output register.
// Throughput: one input per cycle for passthrough bytes while the receiver
// keeps out_ready high; an escaped byte takes three output register loads.
// The output register lets the next byte be taken while a result waits;
// when the receiver stalls, the held item stays in the input register and
// in_ready drops until its last output byte enters the output register.
// Reset clears the valid flags and the slot counter; the payload registers
// are not reset, and no clearing pass is needed.
// Depends on url_enc_pkg, url_enc_classify and url_enc_serializer.
module url_percent_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       end_of_text
);

	logic                   valid_s1;
	logic             [7:0] byte_s1;
	logic                   end_s1;
	logic                   item_done;
	url_enc_pkg::enc_item_t item;

	// Accept when the stage is empty or its last byte leaves this cycle.
	assign in_ready = !valid_s1 || item_done;

	// Hold the input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the input payload on transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			end_s1  <= text_end;
		end
	end

	url_enc_classify u_classify (
		.byte_in (byte_s1),
		.end_in  (end_s1),
		.item    (item)
	);

	url_enc_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item        (item),
		.item_done   (item_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.end_of_text (end_of_text)
	);

endmodule
